// ===== rtl/elp_pkg.sv =====
// Shared types and character constants for the edge list text parser.
`timescale 1ns / 1ps

package elp_pkg;

  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharNewline = 8'h0a;

  typedef struct packed {
    logic [31:0] first_number;
    logic [31:0] second_number;
    logic [47:0] edge_index;
  } edge_t;

endpackage

// ===== rtl/elp_parser.sv =====
// Per-byte parse step: phase and accumulator state, decimal multiply-add, edge emit.
`timescale 1ns / 1ps

module elp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     text_byte_i,
  input  logic           last_byte_i,
  output logic           emit_o,
  output elp_pkg::edge_t edge_o
);
  import elp_pkg::*;

  typedef enum logic [1:0] {
    PhFirst,
    PhSecond,
    PhSkip
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] first_q, first_d, first_upd;
  logic [31:0] second_q, second_d, second_upd;
  logic [47:0] count_q, count_d;
  phase_e      phase_upd;
  logic        is_digit, is_nl, nl_emit;
  logic [31:0] digit;

  assign is_digit = (text_byte_i >= CharZero) && (text_byte_i <= CharNine);
  assign is_nl    = (text_byte_i == CharNewline);
  assign digit    = {24'd0, text_byte_i - CharZero};

  always_comb begin
    phase_upd  = phase_q;
    first_upd  = first_q;
    second_upd = second_q;
    nl_emit    = 1'b0;
    unique case (phase_q)
      PhFirst: begin
        // x*10 as (x<<3)+(x<<1), wrapping at 32 bits
        if (is_digit) begin
          first_upd = (first_q << 3) + (first_q << 1) + digit;
        end else begin
          phase_upd = PhSecond;
        end
      end
      PhSecond: begin
        if (is_digit) begin
          second_upd = (second_q << 3) + (second_q << 1) + digit;
        end else if (is_nl) begin
          nl_emit = 1'b1;
        end else begin
          phase_upd = PhSkip;
        end
      end
      default: begin
        if (is_nl) begin
          nl_emit = 1'b1;
        end
      end
    endcase
  end

  assign emit_o = nl_emit || last_byte_i;

  assign edge_o.first_number  = first_upd;
  assign edge_o.second_number = second_upd;
  assign edge_o.edge_index    = count_q;

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    count_d  = count_q;
    if (step_i) begin
      if (emit_o) begin
        phase_d  = PhFirst;
        first_d  = '0;
        second_d = '0;
        count_d  = count_q + 48'd1;
      end else begin
        phase_d  = phase_upd;
        first_d  = first_upd;
        second_d = second_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFirst;
      first_q  <= '0;
      second_q <= '0;
      count_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/edge_list_text_parser_top.sv =====
// Top level of the edge list text parser: input register, parse step, result register.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid_i, in_ready_o, text_byte_i, last_byte_i | in
//   result  | out_valid_o, out_ready_i, first_number_o,      | out
//           | second_number_o, edge_index_o                  |
//
// One byte per cycle sustained while the result slot is free or taken; a byte enters the
// input register, then the parse step puts its edge in the result register. The parse
// state advances as a byte moves from the input register into the result stage, so a
// held result stalls only that move; the input register still takes one more request.
// Reset clears all valid flags, the parse phase, both accumulators and the edge count.
`timescale 1ns / 1ps

module edge_list_text_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] first_number_o,
  output logic [31:0] second_number_o,
  output logic [47:0] edge_index_o
);
  import elp_pkg::*;

  logic       in_v_q, in_v_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       out_v_q, out_v_d;
  edge_t      edge_q, edge_d;
  edge_t      edge_w;
  logic       emit;
  logic       advance;

  // the input register drains when the result slot is free or being taken
  assign advance    = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || advance;

  elp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .text_byte_i (byte_q),
    .last_byte_i (last_q),
    .emit_o      (emit),
    .edge_o      (edge_w)
  );

  always_comb begin
    in_v_d = in_v_q;
    byte_d = byte_q;
    last_d = last_q;
    if (in_valid_i && in_ready_o) begin
      in_v_d = 1'b1;
      byte_d = text_byte_i;
      last_d = last_byte_i;
    end else if (advance) begin
      in_v_d = 1'b0;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    edge_d  = edge_q;
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    if (advance && emit) begin
      out_v_d = 1'b1;
      edge_d  = edge_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    edge_q <= edge_d;
  end

  assign out_valid_o     = out_v_q;
  assign first_number_o  = edge_q.first_number;
  assign second_number_o = edge_q.second_number;
  assign edge_index_o    = edge_q.edge_index;

endmodule
